// File: sv/ssnl_pkg.sv
`default_nettype none
package ssnl_pkg;

    localparam int STEER_ENTRIES = 16;
    localparam int NAT_ENTRIES   = 128;
    localparam int MAX_ENTRIES   = (NAT_ENTRIES > STEER_ENTRIES) ? NAT_ENTRIES : STEER_ENTRIES;
    localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);

    localparam logic [31:0] SUFFIX_START = 32'd200;

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    localparam logic REG_DEFAULT_DEST = 1'b0;
    localparam logic REG_STEER_COUNT  = 1'b1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [CNT_W-1:0] remain;
        logic [31:0]      key;
        logic [31:0]      data;
    } t_probe;

endpackage
`default_nettype wire

// File: sv/ssnl_cell.sv
`default_nettype none
module ssnl_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_en,
    input  wire logic [31:0]     i_wr_key,
    input  wire logic [31:0]     i_wr_data,
    input  wire ssnl_pkg::t_probe i_probe,
    output ssnl_pkg::t_probe     o_probe
);

    logic [31:0]      r_key;
    logic [31:0]      r_data;
    ssnl_pkg::t_probe r_probe;
    ssnl_pkg::t_probe n_probe;
    logic             match;

    assign match = !i_probe.hit && (i_probe.remain != '0) && (r_key == i_probe.key);

    always_comb begin
        n_probe = i_probe;
        if (match) begin
            n_probe.hit  = 1'b1;
            n_probe.data = r_data;
        end
        if (i_probe.remain != '0) begin
            n_probe.remain = i_probe.remain - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key  <= i_wr_key;
            r_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= i_probe.valid;
        end
        r_probe.hit    <= n_probe.hit;
        r_probe.remain <= n_probe.remain;
        r_probe.key    <= n_probe.key;
        r_probe.data   <= n_probe.data;
    end

    assign o_probe = r_probe;

endmodule
`default_nettype wire

// File: sv/source_steer_and_nat_learn_top.sv
`default_nettype none
// An item is taken when i_start is high and o_busy is low. Loads and
// non-IPv4 packets give their result in the next cycle. An IPv4 packet is sent
// through a steering chain and a NAT chain of cells, one cell per entry and one
// cell per cycle, and its result is registered once both chains are done.
// Each result is shown for one cycle with o_valid high and cannot be held off
// by the receiver.
module source_steer_and_nat_learn_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_opcode,
    input  wire logic        i_is_ipv4,
    input  wire logic [31:0] i_address,
    input  wire logic [15:0] i_in_destination,
    input  wire logic [3:0]  i_entry_index,
    output logic             o_valid,
    output logic [31:0]      o_new_address,
    output logic [15:0]      o_out_destination,
    output logic             o_learned,
    output logic             o_table_full
);

    localparam int CW = ssnl_pkg::CNT_W;

    logic [15:0]       r_default;
    logic [4:0]        r_steer_count;
    logic [CW-1:0]     r_nat_used;
    logic [31:0]       r_suffix;
    ssnl_pkg::t_state  r_state;
    ssnl_pkg::t_state  n_state;
    logic [31:0]       r_addr;
    logic              r_steer_done;
    logic              r_steer_hit;
    logic [15:0]       r_steer_val;
    logic              r_nat_done;
    logic              r_nat_hit;
    logic [31:0]       r_nat_val;

    logic              accept;
    logic              launch;
    logic              finish;
    logic              nat_wr;
    logic [CW-1:0]     steer_limit;
    logic [15:0]       chosen;

    ssnl_pkg::t_probe  steer_p [ssnl_pkg::STEER_ENTRIES+1];
    ssnl_pkg::t_probe  nat_p   [ssnl_pkg::NAT_ENTRIES+1];

    assign accept = i_start && !o_busy;
    assign launch = accept && (i_opcode == ssnl_pkg::OP_PROCESS) && i_is_ipv4;
    assign nat_wr = finish && !r_nat_hit && (int'(r_nat_used) < ssnl_pkg::NAT_ENTRIES);

    assign steer_limit = (int'(r_steer_count) > ssnl_pkg::STEER_ENTRIES) ?
                         CW'(ssnl_pkg::STEER_ENTRIES) : CW'(r_steer_count);

    assign steer_p[0].valid  = launch;
    assign steer_p[0].hit    = 1'b0;
    assign steer_p[0].remain = steer_limit;
    assign steer_p[0].key    = i_address;
    assign steer_p[0].data   = '0;
    assign nat_p[0].valid    = launch;
    assign nat_p[0].hit      = 1'b0;
    assign nat_p[0].remain   = r_nat_used;
    assign nat_p[0].key      = i_address;
    assign nat_p[0].data     = '0;

    for (genvar k = 0; k < ssnl_pkg::STEER_ENTRIES; k++) begin : g_steer
        ssnl_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (accept && (i_opcode == ssnl_pkg::OP_LOAD) &&
                        (int'(i_entry_index) == k)),
            .i_wr_key  (i_address),
            .i_wr_data ({16'd0, i_in_destination}),
            .i_probe   (steer_p[k]),
            .o_probe   (steer_p[k+1])
        );
    end

    for (genvar k = 0; k < ssnl_pkg::NAT_ENTRIES; k++) begin : g_nat
        ssnl_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (nat_wr && (int'(r_nat_used) == k)),
            .i_wr_key  (r_addr),
            .i_wr_data (r_addr | r_suffix),
            .i_probe   (nat_p[k]),
            .o_probe   (nat_p[k+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssnl_pkg::S_IDLE: begin
                if (launch) begin
                    n_state = ssnl_pkg::S_SEARCH;
                end
            end
            ssnl_pkg::S_SEARCH: begin
                if (r_steer_done && r_nat_done) begin
                    n_state = ssnl_pkg::S_IDLE;
                end
            end
            default: n_state = ssnl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != ssnl_pkg::S_IDLE);
        finish = (r_state == ssnl_pkg::S_SEARCH) && r_steer_done && r_nat_done;
    end

    assign chosen = r_steer_hit ? r_steer_val : r_default;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ssnl_pkg::S_IDLE;
            r_default     <= '0;
            r_steer_count <= '0;
            r_nat_used    <= '0;
            r_suffix      <= ssnl_pkg::SUFFIX_START;
            r_steer_done  <= 1'b0;
            r_nat_done    <= 1'b0;
            o_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == ssnl_pkg::REG_DEFAULT_DEST) begin
                    r_default <= i_cfg_data;
                end else begin
                    r_steer_count <= i_cfg_data[4:0];
                end
            end
            if (launch) begin
                r_steer_done <= 1'b0;
                r_nat_done   <= 1'b0;
            end else begin
                if (steer_p[ssnl_pkg::STEER_ENTRIES].valid) begin
                    r_steer_done <= 1'b1;
                end
                if (nat_p[ssnl_pkg::NAT_ENTRIES].valid) begin
                    r_nat_done <= 1'b1;
                end
            end
            if (finish && !r_nat_hit) begin
                r_suffix <= r_suffix + 32'd1;
            end
            if (nat_wr) begin
                r_nat_used <= r_nat_used + 1'b1;
            end
            o_valid <= (accept && !launch) || finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_addr <= i_address;
        end
        if (steer_p[ssnl_pkg::STEER_ENTRIES].valid) begin
            r_steer_hit <= steer_p[ssnl_pkg::STEER_ENTRIES].hit;
            r_steer_val <= steer_p[ssnl_pkg::STEER_ENTRIES].data[15:0];
        end
        if (nat_p[ssnl_pkg::NAT_ENTRIES].valid) begin
            r_nat_hit <= nat_p[ssnl_pkg::NAT_ENTRIES].hit;
            r_nat_val <= nat_p[ssnl_pkg::NAT_ENTRIES].data;
        end
        if (finish) begin
            o_new_address     <= r_nat_hit ? r_nat_val : (r_addr | r_suffix);
            o_out_destination <= (chosen == 16'd0) ? r_default : chosen;
            o_learned         <= !r_nat_hit;
            o_table_full      <= !r_nat_hit &&
                                 (int'(r_nat_used) >= ssnl_pkg::NAT_ENTRIES);
        end else if (accept && !launch) begin
            o_new_address <= i_address;
            o_learned     <= 1'b0;
            o_table_full  <= 1'b0;
            if ((i_opcode == ssnl_pkg::OP_PROCESS) && (i_in_destination == 16'd0)) begin
                o_out_destination <= r_default;
            end else begin
                o_out_destination <= i_in_destination;
            end
        end
    end

endmodule
`default_nettype wire
